/* src/gfr_pkg.sv */
package gfr_pkg;

	// Frame geometry and protocol constants.
	localparam int STATE_BYTES = 8;
	localparam int POS_W = 4;
	localparam logic [7:0] HEADER_BYTE = 8'h7a;
	localparam logic [3:0] DPAD_MASK = 4'hf;
	localparam logic [POS_W-1:0] LEN_ANALOG = POS_W'(14);
	localparam logic [POS_W-1:0] LEN_DIGITAL = POS_W'(12);
	localparam logic [POS_W-1:0] PAYLOAD_START = POS_W'(4);
	localparam logic [POS_W-1:0] PAYLOAD_END = POS_W'(4 + STATE_BYTES);
	localparam int CAP_IDX_W = $clog2(STATE_BYTES);

	// Depth of the command queue between front and back.
	localparam int CMD_DEPTH = 2;
	localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
	localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

	// Report status codes.
	localparam logic [1:0] STATUS_GOOD = 2'd0;
	localparam logic [1:0] STATUS_BAD = 2'd1;
	localparam logic [1:0] STATUS_CLEAR = 2'd2;

	typedef struct packed {
		logic op;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] buttons_low;
		logic [7:0] buttons_high;
		logic [7:0] left_x;
		logic [7:0] left_y;
		logic [7:0] right_x;
		logic [7:0] right_y;
		logic [7:0] left_trigger;
		logic [7:0] right_trigger;
	} result_t;

	// Command from the frame tracker to the report stage.
	typedef struct packed {
		logic [1:0] status;
		logic [STATE_BYTES-1:0][7:0] state_bytes;
	} cmd_t;

endpackage

/* src/gfr_front.sv */
module gfr_front (
	input  logic clk,
	input  logic arst_n,
	input  logic analog_mode,
	input  logic accept,
	input  gfr_pkg::item_t item,
	output logic cmd_push,
	output gfr_pkg::cmd_t cmd
);
	import gfr_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic [7:0] xor_q;
	logic hdr_q;
	logic [STATE_BYTES-1:0][7:0] capture_q;

	logic [POS_W-1:0] last_pos;
	logic frame_end;
	logic in_payload;
	logic [POS_W-1:0] cap_off;
	logic good;

	assign last_pos = analog_mode ? (LEN_ANALOG - POS_W'(1)) : (LEN_DIGITAL - POS_W'(1));
	assign frame_end = (pos_q >= last_pos);
	assign in_payload = (pos_q >= PAYLOAD_START) && (pos_q < PAYLOAD_END);
	assign cap_off = pos_q - PAYLOAD_START;
	assign good = hdr_q && (item.rx_byte == xor_q);

	always_comb begin
		cmd_push = accept && (item.op || frame_end);
		cmd.state_bytes = capture_q;
		if (!analog_mode) begin
			// Digital frames carry trailer and checksum where the triggers would be.
			cmd.state_bytes[6] = 8'h00;
			cmd.state_bytes[7] = 8'h00;
		end
		if (item.op) begin
			cmd.status = STATUS_CLEAR;
		end else if (good) begin
			cmd.status = STATUS_GOOD;
		end else begin
			cmd.status = STATUS_BAD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			xor_q <= '0;
			hdr_q <= 1'b0;
		end else if (accept) begin
			if (item.op || frame_end) begin
				pos_q <= '0;
				xor_q <= '0;
				hdr_q <= 1'b0;
			end else begin
				if (pos_q == '0) begin
					hdr_q <= (item.rx_byte == HEADER_BYTE);
				end
				xor_q <= xor_q ^ item.rx_byte;
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

	// Every capture slot that a good frame commits is rewritten within that frame.
	always_ff @(posedge clk) begin
		if (accept && !item.op && !frame_end && in_payload) begin
			capture_q[cap_off[CAP_IDX_W-1:0]] <= item.rx_byte;
		end
	end

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= (LEN_ANALOG - POS_W'(1)))
		else $error("frame position ran past the longest frame");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |=> (pos_q == '0) && (xor_q == '0) && !hdr_q)
		else $error("frame tracker did not restart after a report");

endmodule

/* src/gfr_cmd_fifo.sv */
module gfr_cmd_fifo (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  gfr_pkg::cmd_t din,
	output logic full,
	input  logic take,
	output logic valid,
	output gfr_pkg::cmd_t dout
);
	import gfr_pkg::*;

	cmd_t mem_q [CMD_DEPTH];
	logic [CMD_PTR_W-1:0] wr_ptr_q;
	logic [CMD_PTR_W-1:0] rd_ptr_q;
	logic [CMD_CNT_W-1:0] count_q;

	logic do_push;
	logic do_take;

	assign full = (count_q == CMD_CNT_W'(CMD_DEPTH));
	assign valid = (count_q != '0);
	assign dout = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_take = take && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_q + CMD_PTR_W'(1);
			end
			if (do_take) begin
				rd_ptr_q <= (rd_ptr_q == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_q + CMD_PTR_W'(1);
			end
			if (do_push && !do_take) begin
				count_q <= count_q + CMD_CNT_W'(1);
			end else if (do_take && !do_push) begin
				count_q <= count_q - CMD_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("command pushed into a full queue");

endmodule

/* src/gfr_back.sv */
module gfr_back (
	input  logic clk,
	input  logic arst_n,
	input  logic analog_mode,
	input  logic cmd_valid,
	input  gfr_pkg::cmd_t cmd,
	output logic cmd_take,
	input  logic pop,
	output logic empty,
	output gfr_pkg::result_t result
);
	import gfr_pkg::*;

	logic [STATE_BYTES-1:0][7:0] committed_q;
	logic out_valid_q;
	result_t result_q;

	logic [STATE_BYTES-1:0][7:0] committed_next;
	result_t report;

	assign cmd_take = cmd_valid && (!out_valid_q || pop);
	assign empty = !out_valid_q;
	assign result = result_q;

	always_comb begin
		case (cmd.status)
			STATUS_GOOD: committed_next = cmd.state_bytes;
			STATUS_CLEAR: committed_next = '0;
			default: committed_next = committed_q;
		endcase
	end

	// Remap the committed state bytes into the report layout.
	always_comb begin
		logic [7:0] s0;
		logic [7:0] s1;
		s0 = committed_next[0];
		s1 = committed_next[1];
		report.status = cmd.status;
		report.buttons_low = {s1[7], s1[6], s0[5], s0[4], s1[3:0] & DPAD_MASK};
		report.buttons_high = {s0[0], s0[3], s0[1], s0[2], 1'b0, s0[5] & s0[4], s0[7], s0[6]};
		report.left_x = committed_next[2];
		report.left_y = committed_next[3];
		report.right_x = committed_next[4];
		report.right_y = committed_next[5];
		report.left_trigger = analog_mode ? committed_next[6] : 8'h00;
		report.right_trigger = analog_mode ? committed_next[7] : 8'h00;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			committed_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd_take) begin
				committed_q <= committed_next;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			result_q <= report;
		end
	end

	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_take && (cmd.status == STATUS_CLEAR)) |=>
			(committed_q == '0) && (result_q.buttons_low == 8'h00)
			&& (result_q.buttons_high == 8'h00))
		else $error("reset report did not clear the state");

endmodule

/* src/gamepad_frame_receiver_unit.sv */
// Gamepad frame receiver.
// Input channel: a beat carries one item (op, rx_byte) and is taken on a rising edge
// with push high and full low. op low delivers a controller byte; op high clears the
// frame position and the committed state, and yields a report with status "cleared".
// Bytes are counted into frames of 14 bytes (analog_mode high) or 12 (analog_mode low).
// The frame end yields one report: status good or bad plus the remapped buttons, sticks
// and triggers. Bytes inside a frame yield nothing.
// Result channel: the oldest report is on result while empty is low, and is taken on a
// rising edge with pop high. Configuration: the analog_mode bit is written on a beat
// with cfg_valid and cfg_ready high; cfg_ready is always high.
// A report passes through the command queue and is then registered onto the result port.
// Throughput: one input beat per cycle while full is low; the report stage drains one
// queued command a cycle, so a stream of reset items also runs at one per cycle while
// pop keeps up. When the receiver stalls, reports back up into the two-entry command
// queue, full rises and input is held off; bytes inside a frame are then held off too.
// At reset the frame position, checksum and committed state are zero, analog_mode is 1
// and no report is waiting.
module gamepad_frame_receiver_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  gfr_pkg::item_t item,
	output logic empty,
	input  logic pop,
	output gfr_pkg::result_t result,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic cfg_data
);
	import gfr_pkg::*;

	logic analog_mode_q;
	logic accept;
	logic cmd_push;
	cmd_t cmd_in;
	logic cmd_full;
	logic cmd_take;
	logic cmd_valid;
	cmd_t cmd_out;

	// Always ready; the user must write only while idle; the block does not check it.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			analog_mode_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			analog_mode_q <= cfg_data;
		end
	end

	// Input is held off whenever the command queue cannot take another report.
	assign full = cmd_full;
	assign accept = push && !cmd_full;

	gfr_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.analog_mode(analog_mode_q),
		.accept(accept),
		.item(item),
		.cmd_push(cmd_push),
		.cmd(cmd_in)
	);

	gfr_cmd_fifo u_cmd_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(cmd_push),
		.din(cmd_in),
		.full(cmd_full),
		.take(cmd_take),
		.valid(cmd_valid),
		.dout(cmd_out)
	);

	gfr_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.analog_mode(analog_mode_q),
		.cmd_valid(cmd_valid),
		.cmd(cmd_out),
		.cmd_take(cmd_take),
		.pop(pop),
		.empty(empty),
		.result(result)
	);

endmodule

/* tb/sv/gamepad_frame_receiver_unit_tb.sv */
module gamepad_frame_receiver_unit_tb;
	import gfr_pkg::*;

	// Input beat kinds and trigger modes, written by name throughout.
	localparam bit OP_BYTE = 1'b0;
	localparam bit OP_CLEAR = 1'b1;
	localparam bit MODE_DIGITAL = 1'b0;
	localparam bit MODE_ANALOG = 1'b1;

	// Shapes of frame that the stimulus builds.
	localparam int FRAME_GOOD = 0;
	localparam int FRAME_BAD_HEADER = 1;
	localparam int FRAME_BAD_SUM = 2;
	localparam int FRAME_GARBAGE = 3;

	// A quiet wait of SETTLE_CYCLES lets the block settle before the mode is changed.
	localparam int SETTLE_CYCLES = 4;
	localparam int MAX_REPORTED = 10;
	localparam int CHUNK_BEATS = 85;

	// Shadow of the receiver: it follows every accepted beat, works out
	// the report that a frame end or a clear should produce, and matches
	// the reports that leave the block against that list in order.
	class pad_report_board;
		bit analog;
		logic [POS_W-1:0] pos;
		logic [7:0] xsum;
		bit hdr_ok;
		logic [7:0] capture [STATE_BYTES];
		logic [7:0] committed [STATE_BYTES];
		result_t pending_reports [$];
		int faults;
		int reports_out;
		int n_good;
		int n_bad;
		int n_clear;

		function new();
			analog = MODE_ANALOG;
			clear_frame();
			foreach (committed[i]) committed[i] = '0;
		endfunction

		function void clear_frame();
			pos = '0;
			xsum = '0;
			hdr_ok = 1'b0;
			foreach (capture[i]) capture[i] = '0;
		endfunction

		function void set_mode(bit m);
			analog = m;
		endfunction

		// Remaps the committed state bytes into the report layout.
		function result_t build_report(logic [1:0] st);
			result_t r;
			logic [7:0] s0;
			logic [7:0] s1;
			s0 = committed[0];
			s1 = committed[1];
			r.status = st;
			r.buttons_low = {s1[7], s1[6], s0[5], s0[4], s1[3:0] & DPAD_MASK};
			// Guide is only ever pressed as start and select together.
			r.buttons_high = {s0[0], s0[3], s0[1], s0[2], 1'b0, s0[5] & s0[4], s0[7], s0[6]};
			r.left_x = committed[2];
			r.left_y = committed[3];
			r.right_x = committed[4];
			r.right_y = committed[5];
			r.left_trigger = analog ? committed[STATE_BYTES-2] : 8'h00;
			r.right_trigger = analog ? committed[STATE_BYTES-1] : 8'h00;
			return r;
		endfunction

		function void note_item(item_t it);
			logic [POS_W-1:0] len;
			bit good;
			len = analog ? LEN_ANALOG : LEN_DIGITAL;
			if (it.op == OP_CLEAR) begin
				clear_frame();
				foreach (committed[i]) committed[i] = '0;
				pending_reports.push_back(build_report(STATUS_CLEAR));
				return;
			end
			// The length is read afresh on every byte, so a mode change can
			// make the current byte the checksum of a shortened frame.
			if (pos < len - 1'b1) begin
				if (pos == '0) hdr_ok = (it.rx_byte == HEADER_BYTE);
				if (pos >= PAYLOAD_START && pos < PAYLOAD_END)
					capture[CAP_IDX_W'(pos - PAYLOAD_START)] = it.rx_byte;
				xsum = xsum ^ it.rx_byte;
				pos = pos + 1'b1;
			end else begin
				good = hdr_ok && (it.rx_byte == xsum);
				if (good) begin
					foreach (committed[i]) committed[i] = capture[i];
					// Digital frames carry trailer and checksum where the
					// triggers would be, so those bytes are held at zero.
					if (!analog) begin
						committed[STATE_BYTES-2] = '0;
						committed[STATE_BYTES-1] = '0;
					end
				end
				clear_frame();
				pending_reports.push_back(build_report(good ? STATUS_GOOD : STATUS_BAD));
			end
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				faults++;
				if (faults <= MAX_REPORTED)
					$display("Report %0d, %s: expected %h, got %h", reports_out, name, want, got);
			end
		endfunction

		function void check_report(result_t got);
			result_t want;
			if (pending_reports.size() == 0) begin
				faults++;
				if (faults <= MAX_REPORTED)
					$display("Report with nothing expected: %p", got);
				return;
			end
			want = pending_reports.pop_front();
			reports_out++;
			if (want.status == STATUS_GOOD) n_good++;
			else if (want.status == STATUS_BAD) n_bad++;
			else n_clear++;
			compare_field("status", 8'(want.status), 8'(got.status));
			compare_field("buttons_low", want.buttons_low, got.buttons_low);
			compare_field("buttons_high", want.buttons_high, got.buttons_high);
			compare_field("left_x", want.left_x, got.left_x);
			compare_field("left_y", want.left_y, got.left_y);
			compare_field("right_x", want.right_x, got.right_x);
			compare_field("right_y", want.right_y, got.right_y);
			compare_field("left_trigger", want.left_trigger, got.left_trigger);
			compare_field("right_trigger", want.right_trigger, got.right_trigger);
		endfunction
	endclass

	// Every input has a known value from time zero.
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_data = 1'b0;
	item_t item_in = '0;
	logic full;
	logic empty;
	logic cfg_ready;
	result_t report;

	pad_report_board board;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int items_sent = 0;
	int mode_writes = 0;
	bit cur_mode = MODE_ANALOG;

	gamepad_frame_receiver_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item_in),
		.empty(empty),
		.pop(pop),
		.result(report),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// The receiver stalls at random, at whatever rate the current phase sets.
	always @(posedge clk) begin
		pop <= ($urandom_range(99) >= rx_idle_pct);
	end

	// All handshakes are sampled at the rising edge, where every signal
	// still holds its value from before the edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) board.set_mode(cfg_data);
			if (pop && !empty) board.check_report(report);
			if (push && !full) board.note_item(item_in);
		end
	end

	// Offers one beat, with random idle cycles first, and returns at the
	// edge that takes it. push stays high so that beats can run back to back.
	task automatic send_item(bit op, logic [7:0] b);
		while ($urandom_range(99) < tx_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item_in.op <= op;
		item_in.rx_byte <= b;
		do @(posedge clk); while (full);
		items_sent++;
	endtask

	// Holds the sender off until every report owed has been taken, then
	// lets the block settle, since bytes inside a frame owe no report.
	// The first falling edge lets the last beat reach the shadow first.
	task automatic drain();
		push <= 1'b0;
		@(negedge clk);
		while (board.pending_reports.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Sends the first n beats of a frame of the current length. The shape
	// decides whether header and checksum are right; fill below zero means
	// random payload, otherwise every payload byte takes that value.
	task automatic send_frame(int kind, int n, int fill);
		int flen;
		logic [7:0] b;
		logic [7:0] sum;
		flen = cur_mode ? int'(LEN_ANALOG) : int'(LEN_DIGITAL);
		sum = '0;
		for (int i = 0; i < n; i++) begin
			if (kind == FRAME_GARBAGE)
				b = 8'($urandom);
			else if (i == 0)
				b = (kind == FRAME_BAD_HEADER) ? HEADER_BYTE ^ 8'($urandom_range(1, 255))
					: HEADER_BYTE;
			else if (i == flen - 1)
				b = (kind == FRAME_BAD_SUM) ? sum ^ 8'($urandom_range(1, 255)) : sum;
			else if (fill < 0)
				b = 8'($urandom);
			else
				b = 8'(fill);
			send_item(OP_BYTE, b);
			sum = sum ^ b;
		end
	endtask

	// Changes the trigger mode on an idle block. A frame is usually left
	// open at this point, so the new length takes effect in mid frame; the
	// frame is then closed, half the time with the checksum that makes it good.
	task automatic write_mode(bit m);
		int flen;
		int fill_n;
		logic [7:0] b;
		logic [7:0] sum;
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= m;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_mode = m;
		mode_writes++;
		flen = m ? int'(LEN_ANALOG) : int'(LEN_DIGITAL);
		if (board.pos != '0) begin
			fill_n = (int'(board.pos) < flen - 1) ? flen - int'(board.pos) : 1;
			sum = board.xsum;
			for (int i = 1; i < fill_n; i++) begin
				b = 8'($urandom);
				send_item(OP_BYTE, b);
				sum = sum ^ b;
			end
			send_item(OP_BYTE, $urandom_range(1) ? sum : 8'($urandom));
		end
	endtask

	// Mostly well-formed frames with random content, mixed with broken
	// headers and checksums, frames cut short by a clear, garbage and lone
	// clears. The chunk usually ends with a frame left open.
	task automatic run_chunk(int beats);
		int first;
		int pick;
		int flen;
		first = items_sent;
		flen = cur_mode ? int'(LEN_ANALOG) : int'(LEN_DIGITAL);
		while (items_sent - first < beats) begin
			pick = $urandom_range(99);
			if (pick < 66)
				send_frame(FRAME_GOOD, flen, -1);
			else if (pick < 70)
				send_frame(FRAME_GOOD, flen, $urandom_range(1) ? 255 : 0);
			else if (pick < 78)
				send_frame(FRAME_BAD_HEADER, flen, -1);
			else if (pick < 86)
				send_frame(FRAME_BAD_SUM, flen, -1);
			else if (pick < 91) begin
				send_frame(FRAME_GOOD, $urandom_range(1, flen - 1), -1);
				send_item(OP_CLEAR, 8'($urandom));
			end else if (pick < 95)
				send_frame(FRAME_GARBAGE, flen, -1);
			else
				send_item(OP_CLEAR, 8'($urandom));
		end
		send_frame(FRAME_GOOD, $urandom_range(0, flen - 1), -1);
	endtask

	initial begin
		board = new();
		tx_idle_pct = 25;
		rx_idle_pct = 76;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening: a clear whose byte must be ignored, a good
		// analog frame with every state bit set so that guide and both
		// triggers light up, a clear back to zero, and the same frame in
		// digital mode, where the triggers must read zero.
		send_item(OP_CLEAR, 8'hff);
		send_frame(FRAME_GOOD, int'(LEN_ANALOG), 255);
		send_item(OP_CLEAR, 8'h00);
		write_mode(MODE_DIGITAL);
		send_frame(FRAME_GOOD, int'(LEN_DIGITAL), 255);

		// Three idling phases, the mode flipping between chunks.
		for (int p = 0; p < 3; p++) begin
			if (p == 1) begin
				tx_idle_pct = 76;
				rx_idle_pct = 25;
			end else if (p == 2) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			for (int c = 0; c < 4; c++) begin
				write_mode(((p + c) % 2 == 0) ? MODE_ANALOG : MODE_DIGITAL);
				run_chunk(CHUNK_BEATS);
			end
		end

		drain();
		board.faults += board.pending_reports.size();
		$display("Sent %0d beats through %0d mode writes across three idling phases.",
			items_sent, mode_writes);
		$display("Checked %0d reports: %0d good frames, %0d bad frames, %0d clears.",
			board.reports_out, board.n_good, board.n_bad, board.n_clear);
		if (board.faults == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d mismatches in total.", board.faults);
			$display("Regression FAIL");
		end
		$finish;
	end

	// Guard against a hung handshake; a correct run needs a small fraction of this.
	initial begin
		#2000000;
		$display("Timed out waiting on the block.");
		$display("Regression FAIL");
		$finish;
	end

endmodule
